// ===== src/kvt_pkg.sv =====
package kvt_pkg;

  localparam int unsigned KindW   = 2;
  localparam int unsigned KeyW    = 64;
  localparam int unsigned ValueW  = 32;
  localparam int unsigned PosW    = 5;
  localparam int unsigned StatusW = 2;
  localparam int unsigned FposW   = 6;
  localparam int unsigned CountW  = 6;

  typedef enum logic [KindW-1:0] {
    KIND_ADD    = 2'd0,
    KIND_DELETE = 2'd1,
    KIND_LOOKUP = 2'd2,
    KIND_READ   = 2'd3
  } kind_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK      = 2'd0,
    ST_MISSING = 2'd1,
    ST_FULL    = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_RDPOS,
    S_RESP
  } state_e;

  typedef struct packed {
    status_e                  status;
    logic signed [ValueW-1:0] read_value;
    logic [FposW-1:0]         found_position;
    logic [CountW-1:0]        entry_count;
  } result_t;

endpackage

// ===== src/kvt_in_if.sv =====
interface kvt_in_if;
  import kvt_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [KindW-1:0]         kind;
  logic [KeyW-1:0]          key;
  logic signed [ValueW-1:0] write_value;
  logic [PosW-1:0]          position;

  modport source (output valid, kind, key, write_value, position, input ready);
  modport sink (input valid, kind, key, write_value, position, output ready);
endinterface

// ===== src/kvt_out_if.sv =====
interface kvt_out_if;
  import kvt_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [StatusW-1:0]       status;
  logic signed [ValueW-1:0] read_value;
  logic [FposW-1:0]         found_position;
  logic [CountW-1:0]        entry_count;

  modport source (output valid, status, read_value, found_position, entry_count, input ready);
  modport sink (input valid, status, read_value, found_position, entry_count, output ready);
endinterface

// ===== src/kvt_ram.sv =====
module kvt_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 4
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                         wdata_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Registered read; a write becomes visible to reads issued in the cycle after it.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule

// ===== src/keyed_variable_table.sv =====
// Channel  Dir  Handshake       Payload
// in_i     in   valid / ready   kind, key, write_value, position
// out_o    out  valid / ready   status, read_value, found_position, entry_count
//
// Add, delete and lookup scan the table one entry per cycle through the single
// read port of the entry memory. The scan stops at the first entry whose key
// matches, or after the last entry on a miss.
// A delete then moves each later entry down by one slot, one entry per cycle.
// Read by position fetches the addressed entry. A read past the count, or
// any operation on an empty table, skips the memory read. The input is ready
// again in the cycle after the result is loaded into the output register.
// Reset clears the entry count, the state machine and the output valid; the
// memory needs no clearing pass because entries at or above the count are never
// read. A stalled result sits in the output register while the next transaction
// is accepted and processed. That next result then waits until the register frees.
module keyed_variable_table #(
  parameter int unsigned DEPTH     = 32,
  parameter int unsigned KEY_BYTES = 8
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  kvt_in_if.sink    in_i,
  kvt_out_if.source out_o
);
  import kvt_pkg::*;

  // Stored key width, memory address width and count width.
  localparam int unsigned KW = 8 * KEY_BYTES;
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned EW = KW + ValueW;

  state_e                   state_q, state_d;
  kind_e                    kind_q, kind_d;
  logic [KW-1:0]            key_q, key_d;
  logic signed [ValueW-1:0] wval_q, wval_d;
  logic [CW-1:0]            idx_q, idx_d;
  logic [CW-1:0]            count_q, count_d;
  result_t                  res_q, res_d;
  result_t                  out_q, out_d;
  logic                     out_valid_q, out_valid_d;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [EW-1:0] ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [EW-1:0] ram_rdata;

  logic [KW-1:0]            rd_key;
  logic signed [ValueW-1:0] rd_val;
  logic [CW-1:0]            idx_next;
  logic [KW-1:0]            in_key;
  logic                     in_accept;

  // Each memory word holds one entry: key in the upper bits, value below.
  kvt_ram #(
    .Width(EW),
    .Depth(DEPTH)
  ) u_entry_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign rd_key    = ram_rdata[EW-1:ValueW];
  assign rd_val    = ram_rdata[ValueW-1:0];
  assign idx_next  = idx_q + CW'(1);
  assign in_key    = in_i.key[KW-1:0];
  assign in_i.ready = (state_q == S_IDLE);
  assign in_accept = in_i.valid && in_i.ready;

  always_comb begin
    state_d     = state_q;
    kind_d      = kind_q;
    key_d       = key_q;
    wval_d      = wval_q;
    idx_d       = idx_q;
    count_d     = count_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    ram_we      = 1'b0;
    ram_waddr   = '0;
    ram_wdata   = {key_q, wval_q};
    ram_raddr   = '0;

    // The output register empties when its transaction completes.
    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          kind_d = kind_e'(in_i.kind);
          key_d  = in_key;
          wval_d = in_i.write_value;
          res_d.status         = ST_MISSING;
          res_d.read_value     = '0;
          res_d.found_position = '0;
          res_d.entry_count    = CountW'(count_q);
          if (kind_e'(in_i.kind) == KIND_READ) begin
            if ((32'(in_i.position) < 32'(count_q)) && (32'(in_i.position) < DEPTH)) begin
              ram_raddr = AW'(in_i.position);
              idx_d     = CW'(in_i.position);
              state_d   = S_RDPOS;
            end else begin
              state_d = S_RESP;
            end
          end else if (count_q == '0) begin
            // Empty table: nothing to scan, an add lands in the first slot.
            if (kind_e'(in_i.kind) == KIND_ADD) begin
              ram_we            = 1'b1;
              ram_waddr         = '0;
              ram_wdata         = {in_key, in_i.write_value};
              count_d           = CW'(1);
              res_d.status      = ST_OK;
              res_d.entry_count = CountW'(1);
            end
            state_d = S_RESP;
          end else begin
            ram_raddr = '0;
            idx_d     = '0;
            state_d   = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        // Read data holds the entry at idx_q.
        if (rd_key == key_q) begin
          res_d.status         = ST_OK;
          res_d.found_position = FposW'(idx_q);
          state_d              = S_RESP;
          case (kind_q)
            KIND_LOOKUP: begin
              res_d.read_value = rd_val;
            end
            KIND_ADD: begin
              ram_we    = 1'b1;
              ram_waddr = AW'(idx_q);
            end
            KIND_DELETE: begin
              if (idx_next < count_q) begin
                ram_raddr = AW'(idx_next);
                idx_d     = idx_next;
                state_d   = S_SHIFT;
              end else begin
                count_d           = count_q - CW'(1);
                res_d.entry_count = CountW'(count_q - CW'(1));
              end
            end
            default: begin
              state_d = S_RESP;
            end
          endcase
        end else if (idx_next < count_q) begin
          ram_raddr = AW'(idx_next);
          idx_d     = idx_next;
        end else begin
          // No entry holds the key.
          state_d = S_RESP;
          if (kind_q == KIND_ADD) begin
            if (count_q == CW'(DEPTH)) begin
              res_d.status = ST_FULL;
            end else begin
              ram_we               = 1'b1;
              ram_waddr            = AW'(count_q);
              count_d              = count_q + CW'(1);
              res_d.status         = ST_OK;
              res_d.found_position = FposW'(count_q);
              res_d.entry_count    = CountW'(count_q + CW'(1));
            end
          end
        end
      end

      S_SHIFT: begin
        // Move the entry at idx_q down by one while fetching the next one.
        ram_we    = 1'b1;
        ram_waddr = AW'(idx_q - CW'(1));
        ram_wdata = ram_rdata;
        if (idx_next < count_q) begin
          ram_raddr = AW'(idx_next);
          idx_d     = idx_next;
        end else begin
          count_d           = count_q - CW'(1);
          res_d.entry_count = CountW'(count_q - CW'(1));
          state_d           = S_RESP;
        end
      end

      S_RDPOS: begin
        res_d.status         = ST_OK;
        res_d.read_value     = rd_val;
        res_d.found_position = FposW'(idx_q);
        state_d              = S_RESP;
      end

      S_RESP: begin
        if (!out_valid_q || out_o.ready) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;
    key_q  <= key_d;
    wval_q <= wval_d;
    idx_q  <= idx_d;
    res_q  <= res_d;
    out_q  <= out_d;
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.status         = out_q.status;
  assign out_o.read_value     = out_q.read_value;
  assign out_o.found_position = out_q.found_position;
  assign out_o.entry_count    = out_q.entry_count;
endmodule
